// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held
`define AST_CHK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Constants, types and carve functions of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BASIC_BYTES  = 128;
    localparam int TOTAL_BLOCKS = 1024;
    localparam int HEADER_BYTES = 16;

    localparam int BLK_W      = $clog2(TOTAL_BLOCKS);
    localparam int PTR_W      = BLK_W + 1;
    localparam int NUM_LEVELS = $clog2(TOTAL_BLOCKS + 1);
    localparam int LVL_W      = $clog2(NUM_LEVELS + 1);
    localparam int REQ_W      = 18;
    localparam int LEN_W      = REQ_W + 1;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(TOTAL_BLOCKS);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_A_POP,
        ST_A_SPLIT,
        ST_F_RD,
        ST_F_LV,
        ST_F_WALK,
        ST_F_WAIT,
        ST_F_UNL,
        ST_F_PUSH,
        ST_DONE
    } t_state;

    // head of a level's list after reset
    function automatic logic [PTR_W-1:0] carve_head(input int lv);
        int off;
        off = TOTAL_BLOCKS & ~((2 << lv) - 1);
        if (((TOTAL_BLOCKS >> lv) & 1) != 0) begin
            return PTR_W'(off);
        end
        return NIL;
    endfunction

    // level stored for a block after reset
    function automatic logic [LVL_W-1:0] carve_level(input logic [BLK_W-1:0] blk);
        logic [LVL_W-1:0] res;
        res = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (carve_head(i) == {1'b0, blk}) begin
                res = LVL_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba_if
// Request and response channels of the buddy block allocator.
// ----------------------------------------------------------------------------
interface bba_req_if
    import bba_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             op;
    logic [REQ_W-1:0] request_bytes;
    logic [BLK_W-1:0] free_block;

    modport source (output valid, op, request_bytes, free_block, input ready);
    modport sink   (input valid, op, request_bytes, free_block, output ready);
endinterface

interface bba_rsp_if
    import bba_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             granted;
    logic [BLK_W-1:0] block_start;

    modport source (output valid, granted, block_start, input ready);
    modport sink   (input valid, granted, block_start, output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a pool of basic blocks, list links kept in RAM, list heads in registers.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transfer: op 0 allocates request_bytes
//   (plus header), op 1 frees the block starting at free_block.
//   o_rsp returns one result per request: granted and block_start.
//   One request is worked at a time. Allocate pops the lowest nonempty
//   level that fits and splits down to the fitting level; with no fit it
//   goes straight to done. Free walks its level's list for the buddy,
//   merging and climbing while found, else pushes the block on the list.
//   After reset the block sweeps the link and level RAMs, one entry a
//   cycle, and accepts no request until done. The result sits in an
//   output register, loaded as the block returns to idle for the next
//   request. If the receiver stalls, a finished request holds in its last state until the output register frees.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp
);
    t_state r_state, n_state;

    logic [PTR_W-1:0] r_heads [NUM_LEVELS];
    logic [BLK_W-1:0] r_clr, n_clr;
    logic [LVL_W-1:0] r_k, n_k, r_i, n_i, r_lv, n_lv;
    logic [PTR_W-1:0] r_b, n_b, r_cur, n_cur, r_prev, n_prev, r_bud, n_bud;
    logic [BLK_W-1:0] r_a, n_a;
    logic [PTR_W-1:0] r_steps, n_steps;
    logic             r_split, n_split;
    logic             r_grant, n_grant;
    logic [BLK_W-1:0] r_start, n_start;
    logic             r_out_valid, r_granted;
    logic [BLK_W-1:0] r_block_start;

    // head table port
    logic [LVL_W-1:0] hd_idx;
    logic [PTR_W-1:0] hd_rd;
    logic             hd_we;
    logic [LVL_W-1:0] hd_widx;
    logic [PTR_W-1:0] hd_wdata;

    // RAM ports
    logic             nl_we, bl_we;
    logic [BLK_W-1:0] nl_waddr, bl_waddr, nl_raddr, bl_raddr;
    logic [PTR_W-1:0] nl_wdata, nl_rdata;
    logic [LVL_W-1:0] bl_wdata, bl_rdata;

    logic             accept, out_free, k_found, i_found;
    logic [LEN_W-1:0] len;
    logic [LVL_W-1:0] k_sel, i_sel, lv_clamp, lv_dec, lv_inc;
    logic [PTR_W-1:0] up_blk, bud_blk;

    bba_ram #(.DEPTH(TOTAL_BLOCKS), .WIDTH(PTR_W)) u_links (
        .i_clk   (i_clk),
        .i_we    (nl_we),
        .i_waddr (nl_waddr),
        .i_wdata (nl_wdata),
        .i_raddr (nl_raddr),
        .o_rdata (nl_rdata)
    );

    bba_ram #(.DEPTH(TOTAL_BLOCKS), .WIDTH(LVL_W)) u_levels (
        .i_clk   (i_clk),
        .i_we    (bl_we),
        .i_waddr (bl_waddr),
        .i_wdata (bl_wdata),
        .i_raddr (bl_raddr),
        .o_rdata (bl_rdata)
    );

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign len      = LEN_W'(i_req.request_bytes) + LEN_W'(HEADER_BYTES);
    assign hd_rd    = r_heads[hd_idx];
    assign lv_dec   = r_i - LVL_W'(1);
    assign lv_inc   = r_lv + LVL_W'(1);
    assign up_blk   = r_b ^ (PTR_W'(1) << lv_dec);
    assign bud_blk  = {1'b0, r_a} ^ (PTR_W'(1) << r_lv);
    assign lv_clamp = (bl_rdata >= LVL_W'(NUM_LEVELS)) ? LVL_W'(NUM_LEVELS - 1) : bl_rdata;

    // smallest fitting level, then lowest nonempty level at or above it
    always_comb begin
        k_found = 1'b0;
        k_sel   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if ((32'(BASIC_BYTES) << l) > 32'(len)) begin
                k_found = 1'b1;
                k_sel   = LVL_W'(l);
            end
        end
        i_found = 1'b0;
        i_sel   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (LVL_W'(l) >= k_sel && r_heads[l] != NIL) begin
                i_found = 1'b1;
                i_sel   = LVL_W'(l);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR: begin
                if (r_clr == BLK_W'(TOTAL_BLOCKS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.op == OP_FREE) begin
                        n_state = ST_F_RD;
                    end else if (k_found && i_found) begin
                        n_state = ST_A_POP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_A_POP:   n_state = ST_A_SPLIT;
            ST_A_SPLIT: begin
                if (r_i <= r_k || up_blk >= NIL) begin
                    n_state = ST_DONE;
                end
            end
            ST_F_RD: n_state = ST_F_LV;
            ST_F_LV: begin
                if (32'(r_lv) + 1 < NUM_LEVELS && bud_blk < NIL) begin
                    n_state = ST_F_WALK;
                end else begin
                    n_state = ST_F_PUSH;
                end
            end
            ST_F_WALK: begin
                if (r_cur >= NIL || r_steps >= PTR_W'(TOTAL_BLOCKS)) begin
                    n_state = ST_F_PUSH;
                end else begin
                    n_state = ST_F_WAIT;
                end
            end
            ST_F_WAIT: begin
                if (r_cur == r_bud) begin
                    n_state = ST_F_UNL;
                end else begin
                    n_state = ST_F_WALK;
                end
            end
            ST_F_UNL:  n_state = ST_F_LV;
            ST_F_PUSH: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        n_clr   = r_clr;
        n_k     = r_k;
        n_i     = r_i;
        n_lv    = r_lv;
        n_b     = r_b;
        n_a     = r_a;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_bud   = r_bud;
        n_steps = r_steps;
        n_split = r_split;
        n_grant = r_grant;
        n_start = r_start;
        hd_idx   = r_lv;
        hd_we    = 1'b0;
        hd_widx  = r_lv;
        hd_wdata = hd_rd;
        nl_we    = 1'b0;
        nl_waddr = r_b[BLK_W-1:0];
        nl_wdata = NIL;
        nl_raddr = r_cur[BLK_W-1:0];
        bl_we    = 1'b0;
        bl_waddr = r_b[BLK_W-1:0];
        bl_wdata = r_k;
        bl_raddr = r_a;
        case (r_state)
            ST_CLR: begin
                nl_we    = 1'b1;
                nl_waddr = r_clr;
                nl_wdata = NIL;
                bl_we    = 1'b1;
                bl_waddr = r_clr;
                bl_wdata = carve_level(r_clr);
                n_clr    = r_clr + BLK_W'(1);
            end
            ST_IDLE: begin
                hd_idx   = i_sel;
                n_k      = k_sel;
                n_i      = i_sel;
                n_b      = hd_rd;
                n_split  = 1'b0;
                nl_raddr = hd_rd[BLK_W-1:0];
                n_a      = i_req.free_block;
                bl_raddr = i_req.free_block;
                n_grant  = (i_req.op == OP_FREE);
                n_start  = '0;
            end
            ST_A_POP: begin
                hd_idx   = r_i;
                hd_we    = 1'b1;
                hd_widx  = r_i;
                hd_wdata = nl_rdata;
                nl_we    = 1'b1;
            end
            ST_A_SPLIT: begin
                if (r_i > r_k) begin
                    hd_idx   = lv_dec;
                    hd_we    = 1'b1;
                    hd_widx  = lv_dec;
                    hd_wdata = r_b;
                    nl_we    = 1'b1;
                    nl_wdata = hd_rd;
                    bl_we    = 1'b1;
                    bl_wdata = lv_dec;
                    n_i      = lv_dec;
                    if (up_blk >= NIL) begin
                        n_grant = 1'b0;
                        n_start = '0;
                    end else begin
                        n_b     = up_blk;
                        n_split = 1'b1;
                    end
                end else begin
                    bl_we    = r_split;
                    bl_wdata = r_k;
                    n_grant  = 1'b1;
                    n_start  = r_b[BLK_W-1:0];
                end
            end
            ST_F_RD: begin
                n_lv = lv_clamp;
            end
            ST_F_LV: begin
                hd_idx  = r_lv;
                n_bud   = bud_blk;
                n_cur   = hd_rd;
                n_prev  = NIL;
                n_steps = '0;
            end
            ST_F_WALK: begin
                nl_raddr = r_cur[BLK_W-1:0];
            end
            ST_F_WAIT: begin
                if (r_cur == r_bud) begin
                    if (r_prev == NIL) begin
                        hd_we    = 1'b1;
                        hd_widx  = r_lv;
                        hd_wdata = nl_rdata;
                    end else begin
                        nl_we    = 1'b1;
                        nl_waddr = r_prev[BLK_W-1:0];
                        nl_wdata = nl_rdata;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = nl_rdata;
                    n_steps = r_steps + PTR_W'(1);
                end
            end
            ST_F_UNL: begin
                nl_we    = 1'b1;
                nl_waddr = r_cur[BLK_W-1:0];
                nl_wdata = NIL;
                n_a      = (r_bud[BLK_W-1:0] < r_a) ? r_bud[BLK_W-1:0] : r_a;
                bl_we    = 1'b1;
                bl_waddr = n_a;
                bl_wdata = lv_inc;
                n_lv     = lv_inc;
            end
            ST_F_PUSH: begin
                hd_idx   = r_lv;
                nl_we    = 1'b1;
                nl_waddr = r_a;
                nl_wdata = hd_rd;
                hd_we    = 1'b1;
                hd_widx  = r_lv;
                hd_wdata = {1'b0, r_a};
                n_grant  = 1'b1;
                n_start  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_heads[l] <= carve_head(l);
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (hd_we) begin
                r_heads[hd_widx] <= hd_wdata;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_i     <= n_i;
        r_lv    <= n_lv;
        r_b     <= n_b;
        r_a     <= n_a;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_bud   <= n_bud;
        r_steps <= n_steps;
        r_split <= n_split;
        r_grant <= n_grant;
        r_start <= n_start;
        if (r_state == ST_DONE && out_free) begin
            r_granted     <= r_grant;
            r_block_start <= r_start;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.granted     = r_granted;
    assign o_rsp.block_start = r_block_start;

`include "assert_macros.svh"

    `AST_CHK(a_accept_leaves_idle, i_clk, i_rst_n, accept |=> r_state != ST_IDLE, "accepted request did not start")
    `AST_CHK(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == ST_DONE, "result loaded outside done")
    `AST_CHK(a_clear_sweeps, i_clk, i_rst_n, r_state == ST_CLR |=> (r_state == ST_IDLE || r_clr == $past(r_clr) + BLK_W'(1)), "clear pass skipped an entry")
    `AST_CHK(a_no_accept_while_busy, i_clk, i_rst_n, r_state != ST_IDLE |-> !accept, "request taken during work")

endmodule
